>>> src/assert_macros.svh
// Assertion macros shared by the compass RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed: expression does not hold");
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: consequence one cycle later does not hold");
`else
`define CHK_ALWAYS(lbl, clk, rst_n, expr)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/compass_pkg.sv
// Types and constants of the compass heading block: request and result
// payloads, op codes, CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package compass_pkg;

    typedef enum logic [1:0] {
        OP_HEADING    = 2'd0,
        OP_CAL_BEGIN  = 2'd1,
        OP_CAL_SAMPLE = 2'd2,
        OP_CAL_FINISH = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
    } t_req;

    typedef struct packed {
        logic               heading_valid;
        logic [15:0]        heading;
        logic [3:0]         direction;
        logic signed [15:0] iron_ofs_x;
        logic signed [15:0] iron_ofs_y;
    } t_res;

    // calibration extremes: +/-1000 uT in 1/16 uT counts
    localparam logic signed [15:0] CAL_MIN_INIT = 16'sd16000;
    localparam logic signed [15:0] CAL_MAX_INIT = -16'sd16000;
    // about 0.55 degrees
    localparam logic signed [15:0] DECL_RESET   = 16'sd100;

    localparam int unsigned CORDIC_W     = 44;
    localparam int unsigned COMP_W       = 18;
    localparam int unsigned SCALE_SH     = 24;
    localparam int unsigned ATAN_ENTRIES = 24;

    localparam logic [31:0] ANGLE_HALF  = 32'h8000_0000;
    localparam logic [31:0] ANGLE_ROUND = 32'h0000_8000;
    localparam logic [15:0] DIR_BIAS    = 16'h0800;

    localparam logic DECL_INDEX = 1'b0;

    typedef logic signed [CORDIC_W-1:0] t_cvec;

    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

>>> src/compass_heading_with_hard_iron_cal.sv
// Compass heading with hard-iron calibration: top level.
// Depends on compass_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one request per cycle unless stalled and returns one result per request, in order.
// Calibration ops update the min/max and offset registers as the request is
// taken; a heading request has the offsets subtracted on entry and then runs
// a vectoring CORDIC with one iteration per pipeline stage. The request is
// registered into stage 0, passes through the iteration stages and then the
// output register; throughput is one request per cycle, limited only by
// downstream stall. The declination register is applied at the output stage
// and is written over the APB port at any address with paddr[2] clear.
module compass_heading_with_hard_iron_cal #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  compass_pkg::t_req   i_req,

    output logic                o_valid,
    input  logic                i_stall,
    output compass_pkg::t_res   o_res,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int N  = CORDIC_STEPS;
    localparam int W  = compass_pkg::CORDIC_W;
    localparam int CW = compass_pkg::COMP_W;
    localparam int SH = compass_pkg::SCALE_SH;

    logic               r_vld  [0:N];
    compass_pkg::t_cvec r_x    [0:N];
    compass_pkg::t_cvec r_y    [0:N];
    logic [31:0]        r_z    [0:N];
    logic               r_hv   [0:N];
    logic               r_zero [0:N];
    logic signed [15:0] r_ox   [0:N];
    logic signed [15:0] r_oy   [0:N];

    compass_pkg::t_cvec n_x [1:N];
    compass_pkg::t_cvec n_y [1:N];
    logic [31:0]        n_z [1:N];

    logic               s_ready [0:N];
    logic               out_move;
    logic               in_acc;

    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [15:0] r_hard_x, r_hard_y;
    logic signed [15:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic signed [15:0] n_hard_x, n_hard_y;
    logic signed [15:0] r_decl;

    logic               r_ovld;
    compass_pkg::t_res  r_res;
    compass_pkg::t_res  n_res;

    logic signed [16:0] sum_x, sum_y;
    logic signed [16:0] diff_x, diff_y;
    logic signed [CW-1:0] ext_x, ext_y, pre_x, pre_y;
    logic               pre_neg;
    compass_pkg::t_cvec n_x0, n_y0;
    logic [31:0]        n_z0;
    logic               n_zero0;

    logic [31:0]        z_fin;
    logic [31:0]        z_rnd;
    logic [15:0]        head;
    logic [15:0]        dir_sum;
    logic               cfg_wr;

    // ---------------- handshake ----------------
    assign out_move = !r_ovld || !i_stall;

    always_comb begin
        s_ready[N] = !r_vld[N] || out_move;
        for (int s = N - 1; s >= 0; s--) begin
            s_ready[s] = !r_vld[s] || s_ready[s+1];
        end
    end

    assign o_stall = !s_ready[0];
    assign in_acc  = i_valid && s_ready[0];

    // ---------------- calibration state ----------------
    assign sum_x = {r_max_x[15], r_max_x} + {r_min_x[15], r_min_x};
    assign sum_y = {r_max_y[15], r_max_y} + {r_min_y[15], r_min_y};

    always_comb begin
        n_min_x  = r_min_x;
        n_max_x  = r_max_x;
        n_min_y  = r_min_y;
        n_max_y  = r_max_y;
        n_hard_x = r_hard_x;
        n_hard_y = r_hard_y;
        unique case (i_req.op)
            compass_pkg::OP_CAL_BEGIN: begin
                n_min_x = compass_pkg::CAL_MIN_INIT;
                n_max_x = compass_pkg::CAL_MAX_INIT;
                n_min_y = compass_pkg::CAL_MIN_INIT;
                n_max_y = compass_pkg::CAL_MAX_INIT;
            end
            compass_pkg::OP_CAL_SAMPLE: begin
                if (i_req.mag_x < r_min_x) n_min_x = i_req.mag_x;
                if (i_req.mag_x > r_max_x) n_max_x = i_req.mag_x;
                if (i_req.mag_y < r_min_y) n_min_y = i_req.mag_y;
                if (i_req.mag_y > r_max_y) n_max_y = i_req.mag_y;
            end
            compass_pkg::OP_CAL_FINISH: begin
                n_hard_x = sum_x[16:1];
                n_hard_y = sum_y[16:1];
            end
            compass_pkg::OP_HEADING: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------- offset removal and CORDIC pre-rotation ----------------
    assign diff_x  = {i_req.mag_x[15], i_req.mag_x} - {r_hard_x[15], r_hard_x};
    assign diff_y  = {i_req.mag_y[15], i_req.mag_y} - {r_hard_y[15], r_hard_y};
    assign ext_x   = {diff_x[16], diff_x};
    assign ext_y   = {diff_y[16], diff_y};
    assign pre_neg = diff_x[16];
    assign pre_x   = pre_neg ? -ext_x : ext_x;
    assign pre_y   = pre_neg ? -ext_y : ext_y;
    assign n_x0    = {{(W - CW - SH){pre_x[CW-1]}}, pre_x, {SH{1'b0}}};
    assign n_y0    = {{(W - CW - SH){pre_y[CW-1]}}, pre_y, {SH{1'b0}}};
    assign n_z0    = pre_neg ? compass_pkg::ANGLE_HALF : '0;
    assign n_zero0 = (diff_x == '0) && (diff_y == '0);

    // ---------------- CORDIC iterations, one per stage ----------------
    always_comb begin
        for (int s = 0; s < N; s++) begin
            if (r_y[s][W-1]) begin
                n_x[s+1] = r_x[s] - (r_y[s] >>> s);
                n_y[s+1] = r_y[s] + (r_x[s] >>> s);
                n_z[s+1] = r_z[s] - compass_pkg::ATAN_TAB[s];
            end else begin
                n_x[s+1] = r_x[s] + (r_y[s] >>> s);
                n_y[s+1] = r_y[s] - (r_x[s] >>> s);
                n_z[s+1] = r_z[s] + compass_pkg::ATAN_TAB[s];
            end
        end
    end

    // ---------------- output formatting ----------------
    assign z_fin   = r_zero[N] ? '0 : r_z[N];
    assign z_rnd   = z_fin + compass_pkg::ANGLE_ROUND;
    assign head    = z_rnd[31:16] + r_decl;
    assign dir_sum = head + compass_pkg::DIR_BIAS;

    always_comb begin
        n_res.heading_valid = r_hv[N];
        n_res.heading       = r_hv[N] ? head : '0;
        n_res.direction     = r_hv[N] ? dir_sum[15:12] : '0;
        n_res.iron_ofs_x    = r_ox[N];
        n_res.iron_ofs_y    = r_oy[N];
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= N; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_ovld   <= 1'b0;
            r_min_x  <= compass_pkg::CAL_MIN_INIT;
            r_max_x  <= compass_pkg::CAL_MAX_INIT;
            r_min_y  <= compass_pkg::CAL_MIN_INIT;
            r_max_y  <= compass_pkg::CAL_MAX_INIT;
            r_hard_x <= '0;
            r_hard_y <= '0;
        end else begin
            if (in_acc) begin
                r_min_x  <= n_min_x;
                r_max_x  <= n_max_x;
                r_min_y  <= n_min_y;
                r_max_y  <= n_max_y;
                r_hard_x <= n_hard_x;
                r_hard_y <= n_hard_y;
            end
            if (s_ready[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 0; s < N; s++) begin
                if (s_ready[s+1]) begin
                    r_vld[s+1] <= r_vld[s];
                end
            end
            if (out_move) begin
                r_ovld <= r_vld[N];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[0]) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= n_zero0;
            r_hv[0]   <= (i_req.op == compass_pkg::OP_HEADING);
            r_ox[0]   <= n_hard_x;
            r_oy[0]   <= n_hard_y;
        end
        for (int s = 0; s < N; s++) begin
            if (s_ready[s+1]) begin
                r_x[s+1]    <= n_x[s+1];
                r_y[s+1]    <= n_y[s+1];
                r_z[s+1]    <= n_z[s+1];
                r_zero[s+1] <= r_zero[s];
                r_hv[s+1]   <= r_hv[s];
                r_ox[s+1]   <= r_ox[s];
                r_oy[s+1]   <= r_oy[s];
            end
        end
        if (out_move && r_vld[N]) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_res;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == compass_pkg::DECL_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= compass_pkg::DECL_RESET;
        end else if (cfg_wr) begin
            r_decl <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == compass_pkg::DECL_INDEX) ? {{16{r_decl[15]}}, r_decl} : '0;

    // ---------------- checks ----------------
    `CHK_NEXT(a_cal_begin_resets, i_clk, i_rst_n,
        in_acc && (i_req.op == compass_pkg::OP_CAL_BEGIN),
        (r_min_x == compass_pkg::CAL_MIN_INIT) && (r_max_y == compass_pkg::CAL_MAX_INIT))
    `CHK_NEXT(a_offset_only_on_finish, i_clk, i_rst_n,
        !(in_acc && (i_req.op == compass_pkg::OP_CAL_FINISH)),
        $stable(r_hard_x) && $stable(r_hard_y))
    `CHK_ALWAYS(a_stall_needs_full_entry, i_clk, i_rst_n, !o_stall || r_vld[0])
    `CHK_ALWAYS(a_no_heading_is_zero, i_clk, i_rst_n,
        !(o_valid && !o_res.heading_valid) || ((o_res.heading == '0) && (o_res.direction == '0)))

endmodule
